// File: hdl/cpc_pkg.sv
// cpc_pkg: widths, fixed-point constants, codes and control structs for the
// conductivity probe conditioner. No dependencies; every other file imports it.

package cpc_pkg;

  localparam int VOLTAGE_BITS = 12;
  localparam int TEMP_BITS    = 10;
  localparam int K_BITS       = 22;
  localparam int EC_BITS      = 18;
  localparam int CFG_IDX_BITS = 1;

  // cell constants are in units of 1/K_SCALE; K_SCALE must divide 2e7
  localparam longint unsigned K_SCALE = 1000000;

  localparam logic [K_BITS-1:0]  K_MASK = '1;
  localparam logic [EC_BITS-1:0] EC_MAX = '1;

  localparam longint unsigned V_MAX = (64'd1 << VOLTAGE_BITS) - 64'd1;
  localparam longint unsigned T_MAX = (64'd1 << TEMP_BITS) - 64'd1;

  // compensation factor 1 + 0.0185*(T - 25) = d / 160000, d = 86000 + 185*t16
  localparam longint unsigned D_BASE  = 86000;
  localparam longint unsigned D_SLOPE = 185;
  localparam longint unsigned D_MAX   = D_BASE + D_SLOPE * T_MAX;
  localparam int              D_BITS  = $clog2(D_MAX + 1);

  localparam int VK_BITS = VOLTAGE_BITS + K_BITS;

  // range switch thresholds on v*k: 2.5 and 2.0 mS/cm at 164 mV per mS/cm
  localparam longint unsigned HYST_HI = 410 * K_SCALE;
  localparam longint unsigned HYST_LO = 328 * K_SCALE;

  // ec = round(v*k*40 / (41*d)) -> (v*k*EC_NUM_MUL + 41d) / (82d)
  localparam longint unsigned EC_NUM_MUL  = 2 * (40000000 / K_SCALE);
  localparam longint unsigned EC_HALF_MUL = 41;

  // k = round(a*K_SCALE / (4e7*lv)) -> (a + h) / (2h), h = (2e7/K_SCALE)*lv
  localparam longint unsigned CAL_HALF_MUL = 20000000 / K_SCALE;
  localparam longint unsigned BUF_LO_MUL   = 41 * 1413;
  localparam longint unsigned BUF_HI_MUL   = 41 * 12880;
  localparam longint unsigned A_MAX        = BUF_HI_MUL * D_MAX;
  localparam int              A_BITS       = $clog2(A_MAX + 1);

  // range check of the new constant: 0.5 < a / (4e7*lv) < 1.5
  localparam longint unsigned KDEN_MUL  = 40000000;
  localparam int              KDEN_BITS = $clog2(KDEN_MUL * V_MAX + 1);
  localparam int              CMP_BITS  = (A_BITS + 1 > KDEN_BITS + 2) ? A_BITS + 1
                                                                       : KDEN_BITS + 2;

  // buffer bands on 10*lv (raw mS/cm * 1640)
  localparam longint unsigned TV_MUL      = 10;
  localparam longint unsigned BAND_LO_MIN = 1476;
  localparam longint unsigned BAND_LO_MAX = 3116;
  localparam longint unsigned BAND_HI_MIN = 14760;
  localparam longint unsigned BAND_HI_MAX = 27552;
  localparam longint unsigned TV_MAX      = (TV_MUL * V_MAX > BAND_HI_MAX) ? TV_MUL * V_MAX
                                                                           : BAND_HI_MAX;
  localparam int              TV_BITS     = $clog2(TV_MAX + 1);

  // shared divider: numerator X + half, divisor 2*half
  localparam longint unsigned HALF_EC_MAX  = EC_HALF_MUL * D_MAX;
  localparam longint unsigned HALF_CAL_MAX = CAL_HALF_MUL * V_MAX;
  localparam longint unsigned HALF_MAX     = (HALF_EC_MAX > HALF_CAL_MAX) ? HALF_EC_MAX
                                                                          : HALF_CAL_MAX;
  localparam int HALF_BITS = $clog2(HALF_MAX + 1);
  localparam int DIV_BITS  = HALF_BITS + 1;
  localparam int X_EC_BITS = VK_BITS + $clog2(EC_NUM_MUL + 1);
  localparam int NUM_BITS  = ((X_EC_BITS > A_BITS) ? X_EC_BITS : A_BITS) + 1;
  localparam int CNT_BITS  = $clog2(NUM_BITS);

  typedef enum logic {
    OP_MEASURE   = 1'b0,
    OP_CALIBRATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CAL_OK        = 2'd0,
    CAL_NO_SAMPLE = 2'd1,
    CAL_NO_BAND   = 2'd2,
    CAL_K_RANGE   = 2'd3
  } cal_status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_K_LOW  = 1'b0,
    CFG_K_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_REMUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic scale;
    logic remul;
    logic load;
    logic step;
    logic finish;
  } cpc_cmd_t;

  typedef struct packed {
    logic div_last;
  } cpc_stat_t;

endpackage

// File: hdl/cpc_req_if.sv
// cpc_req_if: request channel (measure / calibrate items) with valid/ready.
// Depends on cpc_pkg for field widths.

interface cpc_req_if import cpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [VOLTAGE_BITS-1:0] voltage_mv;
  logic [TEMP_BITS-1:0]    temperature;

  modport source (output valid, output op, output voltage_mv, output temperature,
                  input ready);
  modport sink   (input valid, input op, input voltage_mv, input temperature,
                  output ready);
endinterface

// File: hdl/cpc_res_if.sv
// cpc_res_if: result channel with valid/ready.
// Depends on cpc_pkg for field widths.

interface cpc_res_if import cpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EC_BITS-1:0] ec_us_cm;
  logic               saturated;
  logic               high_range;
  logic [1:0]         cal_status;
  logic               cal_buffer;
  logic [K_BITS-1:0]  new_k;

  modport source (output valid, output ec_us_cm, output saturated, output high_range,
                  output cal_status, output cal_buffer, output new_k, input ready);
  modport sink   (input valid, input ec_us_cm, input saturated, input high_range,
                  input cal_status, input cal_buffer, input new_k, output ready);
endinterface

// File: hdl/cpc_ctrl.sv
// cpc_ctrl: sequencing state machine and result-valid flag.
// Depends on cpc_pkg (ctl_state_t, cpc_cmd_t, cpc_stat_t).

module cpc_ctrl import cpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cpc_stat_t status,
  output cpc_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_REMUL;
      ST_REMUL: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (status.div_last) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_PREP:  cmd.prep   = 1'b1;
      ST_SCALE: cmd.scale  = 1'b1;
      ST_REMUL: cmd.remul  = 1'b1;
      ST_LOAD:  cmd.load   = 1'b1;
      ST_DIV:   cmd.step   = 1'b1;
      ST_DONE:  cmd.finish = slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/cpc_datapath.sv
// cpc_datapath: cell constants, last sample, fixed-point products, shared
// restoring divider and the result register. Depends on cpc_pkg.

module cpc_datapath import cpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cpc_cmd_t                cmd,
  output cpc_stat_t               status,
  input  logic                    in_op,
  input  logic [VOLTAGE_BITS-1:0] in_voltage_mv,
  input  logic [TEMP_BITS-1:0]    in_temperature,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [K_BITS-1:0]       cfg_data,
  output logic [EC_BITS-1:0]      res_ec_us_cm,
  output logic                    res_saturated,
  output logic                    res_high_range,
  output logic [1:0]              res_cal_status,
  output logic                    res_cal_buffer,
  output logic [K_BITS-1:0]       res_new_k
);

  // request capture
  op_t                     op_r;
  logic [VOLTAGE_BITS-1:0] v_r;
  logic [TEMP_BITS-1:0]    t_r;

  // persistent state
  logic [K_BITS-1:0]       k_low_r, k_high_r, k_act_r;
  logic                    hi_sel_r;
  logic [VOLTAGE_BITS-1:0] last_v_r;
  logic [TEMP_BITS-1:0]    last_t_r;

  // intermediate products
  logic [D_BITS-1:0]    d_r;
  logic [VK_BITS-1:0]   vk_r;
  logic [KDEN_BITS-1:0] kden_r;
  logic [HALF_BITS-1:0] half_r;
  logic [A_BITS-1:0]    a_r;
  logic                 buf_r, band_ok_r, no_samp_r;

  // divider
  logic [DIV_BITS-1:0] div_r, rem_r;
  logic [NUM_BITS-1:0] quo_r;
  logic [CNT_BITS-1:0] cnt_r;

  // result register
  logic [EC_BITS-1:0] ec_r;
  logic               sat_r, hi_out_r, buf_out_r;
  cal_status_t        cal_status_r;
  logic [K_BITS-1:0]  new_k_r;

  logic                 is_cal;
  logic [TEMP_BITS-1:0] t_src;
  logic [TV_BITS-1:0]   tv;
  logic                 band_lo, band_hi;
  logic [NUM_BITS-1:0]  num_x;
  logic [DIV_BITS:0]    rem_sh;
  logic                 q_bit;
  logic                 ec_sat;
  logic [K_BITS-1:0]    k_clip;
  logic [CMP_BITS-1:0]  a2, kden_c;
  logic                 k_in_range;
  logic                 cal_ok;

  assign is_cal = (op_r == OP_CALIBRATE);
  assign t_src  = is_cal ? last_t_r : t_r;

  assign tv      = TV_BITS'(TV_MUL) * TV_BITS'(last_v_r);
  assign band_lo = (tv > TV_BITS'(BAND_LO_MIN)) && (tv < TV_BITS'(BAND_LO_MAX));
  assign band_hi = (tv > TV_BITS'(BAND_HI_MIN)) && (tv < TV_BITS'(BAND_HI_MAX));

  assign num_x = is_cal ? NUM_BITS'(a_r) : NUM_BITS'(vk_r) * NUM_BITS'(EC_NUM_MUL);

  assign rem_sh = {rem_r, quo_r[NUM_BITS-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_r});

  assign status.div_last = (cnt_r == '0);

  assign ec_sat     = (quo_r > NUM_BITS'(EC_MAX));
  assign k_clip     = (quo_r > NUM_BITS'(K_MASK)) ? K_MASK : quo_r[K_BITS-1:0];
  assign a2         = CMP_BITS'(a_r) << 1;
  assign kden_c     = CMP_BITS'(kden_r);
  assign k_in_range = (a2 > kden_c) && (a2 < CMP_BITS'(3) * kden_c);
  assign cal_ok     = cmd.finish && is_cal && !no_samp_r && band_ok_r && k_in_range;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= op_t'(in_op);
      v_r  <= in_voltage_mv;
      t_r  <= in_temperature;
    end
    if (cmd.prep) begin
      d_r       <= D_BITS'(D_BASE) + D_BITS'(D_SLOPE) * D_BITS'(t_src);
      vk_r      <= VK_BITS'(v_r) * VK_BITS'(k_act_r);
      kden_r    <= KDEN_BITS'(KDEN_MUL) * KDEN_BITS'(last_v_r);
      buf_r     <= band_hi;
      band_ok_r <= band_lo || band_hi;
      no_samp_r <= (last_v_r == '0) && (last_t_r == '0);
    end
    if (cmd.scale) begin
      if (is_cal) begin
        half_r <= HALF_BITS'(CAL_HALF_MUL) * HALF_BITS'(last_v_r);
        a_r    <= A_BITS'(buf_r ? BUF_HI_MUL : BUF_LO_MUL) * A_BITS'(d_r);
      end else begin
        half_r <= HALF_BITS'(EC_HALF_MUL) * HALF_BITS'(d_r);
      end
    end
    // product with the constant chosen after the range switch
    if (cmd.remul) begin
      vk_r <= VK_BITS'(v_r) * VK_BITS'(k_act_r);
    end
    if (cmd.load) begin
      quo_r <= num_x + NUM_BITS'(half_r);
      div_r <= {half_r, 1'b0};
      rem_r <= '0;
      cnt_r <= CNT_BITS'(NUM_BITS - 1);
    end else if (cmd.step) begin
      rem_r <= q_bit ? DIV_BITS'(rem_sh - {1'b0, div_r}) : DIV_BITS'(rem_sh);
      quo_r <= {quo_r[NUM_BITS-2:0], q_bit};
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
    if (cmd.finish) begin
      hi_out_r <= hi_sel_r;
      if (!is_cal) begin
        ec_r         <= ec_sat ? EC_MAX : quo_r[EC_BITS-1:0];
        sat_r        <= ec_sat;
        cal_status_r <= CAL_OK;
        buf_out_r    <= 1'b0;
        new_k_r      <= '0;
      end else begin
        ec_r  <= '0;
        sat_r <= 1'b0;
        priority if (no_samp_r) begin
          cal_status_r <= CAL_NO_SAMPLE;
          buf_out_r    <= 1'b0;
          new_k_r      <= '0;
        end else if (!band_ok_r) begin
          cal_status_r <= CAL_NO_BAND;
          buf_out_r    <= 1'b0;
          new_k_r      <= '0;
        end else if (k_in_range) begin
          cal_status_r <= CAL_OK;
          buf_out_r    <= buf_r;
          new_k_r      <= quo_r[K_BITS-1:0];
        end else begin
          cal_status_r <= CAL_K_RANGE;
          buf_out_r    <= buf_r;
          new_k_r      <= k_clip;
        end
      end
    end
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_low_r  <= K_BITS'(K_SCALE);
      k_high_r <= K_BITS'(K_SCALE);
      k_act_r  <= K_BITS'(K_SCALE);
      hi_sel_r <= 1'b0;
      last_v_r <= '0;
      last_t_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_K_LOW:  k_low_r  <= cfg_data;
          CFG_K_HIGH: k_high_r <= cfg_data;
          default: begin
            k_low_r  <= k_low_r;
            k_high_r <= k_high_r;
          end
        endcase
      end else if (cal_ok) begin
        if (buf_r) begin
          k_high_r <= quo_r[K_BITS-1:0];
        end else begin
          k_low_r <= quo_r[K_BITS-1:0];
        end
      end
      // range switch with hysteresis
      if (cmd.scale && !is_cal) begin
        priority if (vk_r > VK_BITS'(HYST_HI)) begin
          k_act_r  <= k_high_r;
          hi_sel_r <= 1'b1;
        end else if (vk_r < VK_BITS'(HYST_LO)) begin
          k_act_r  <= k_low_r;
          hi_sel_r <= 1'b0;
        end
      end
      if (cmd.finish && !is_cal) begin
        last_v_r <= v_r;
        last_t_r <= t_r;
      end
    end
  end

  assign res_ec_us_cm   = ec_r;
  assign res_saturated  = sat_r;
  assign res_high_range = hi_out_r;
  assign res_cal_status = cal_status_r;
  assign res_cal_buffer = buf_out_r;
  assign res_new_k      = new_k_r;

endmodule

// File: hdl/conductivity_probe_conditioner.sv
// conductivity_probe_conditioner: top level, joins cpc_ctrl and cpc_datapath.
// Depends on cpc_pkg, cpc_req_if, cpc_res_if, cpc_ctrl, cpc_datapath.
//
//   channel   direction  handshake     payload
//   in_req    sink       valid/ready   op, voltage_mv, temperature
//   out_res   source     valid/ready   ec_us_cm, saturated, high_range,
//                                      cal_status, cal_buffer, new_k
//   cfg_*     input      cfg_we        cfg_index, cfg_data
//
// Each request steps through PREP, SCALE, REMUL, LOAD, DIV and DONE; the
// bit-serial divider produces one quotient bit per cycle in DIV.
// One request is in work at a time; in_req.ready is high only when idle.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous: both constants and the active constant go to 1.0.

module conductivity_probe_conditioner import cpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  cpc_req_if.sink                 in_req,
  cpc_res_if.source               out_res,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [K_BITS-1:0]       cfg_data
);

  cpc_cmd_t  cmd;
  cpc_stat_t status;

  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cpc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_op          (in_req.op),
    .in_voltage_mv  (in_req.voltage_mv),
    .in_temperature (in_req.temperature),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .res_ec_us_cm   (out_res.ec_us_cm),
    .res_saturated  (out_res.saturated),
    .res_high_range (out_res.high_range),
    .res_cal_status (out_res.cal_status),
    .res_cal_buffer (out_res.cal_buffer),
    .res_new_k      (out_res.new_k)
  );

endmodule
